>>> src/assert_macros.svh
// assertion helpers for the interrupt distributor register bank
// expects clk_i and rst_ni in the scope of the use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IDR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define IDR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/idr_pkg.sv
// shared types and constants of the interrupt distributor register bank
// no dependencies
package idr_pkg;

  localparam int NUM_VCPU_DEF  = 8;
  localparam int MAX_INTID_DEF = 1024;
  localparam int ADDR_W        = 13;
  localparam int WORD_W        = 32;

  typedef enum logic [3:0] {
    CMD_GRP_RD  = 4'd0,
    CMD_GRP_WR  = 4'd1,
    CMD_EN_RD   = 4'd2,
    CMD_SET_EN  = 4'd3,
    CMD_CLR_EN  = 4'd4,
    CMD_PRIO_RD = 4'd5,
    CMD_PRIO_WR = 4'd6,
    CMD_CFG_RD  = 4'd7,
    CMD_CFG_WR  = 4'd8
  } idr_cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_ENABLE  = 2'd1,
    ACT_DISABLE = 2'd2
  } idr_act_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } idr_state_e;

  typedef struct packed {
    logic       trig_edge;
    logic [7:0] prio;
    logic       en;
    logic       grp;
  } idr_rec_t;

  // SGIs come out of reset enabled and edge triggered
  localparam idr_rec_t REC_SGI_RST = '{trig_edge: 1'b1, prio: 8'h00, en: 1'b1, grp: 1'b0};
  localparam idr_rec_t REC_ZERO    = '0;

  // one record on its way through the modify stage
  typedef struct packed {
    logic              start;
    logic              vld;
    logic [4:0]        idx;
    idr_cmd_e          cmd;
    logic [WORD_W-1:0] wdat;
  } idr_stage_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              bank_sel;
    logic              bank_we;
    logic              shr_we;
    logic [ADDR_W-1:0] waddr;
    idr_rec_t          bank_wdata;
    idr_rec_t          shr_wdata;
  } idr_ctrl_t;

  typedef struct packed {
    logic       load;
    logic       oor;
    logic [9:0] base;
    idr_cmd_e   cmd;
  } idr_res_t;

endpackage

>>> src/idr_in_if.sv
// request channel of the interrupt distributor register bank
// depends on nothing
interface idr_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [2:0]  vcpu_select;
  logic [7:0]  word_offset;
  logic [31:0] write_data;

  modport source (output valid, cmd, vcpu_select, word_offset, write_data, input ready);
  modport sink (input valid, cmd, vcpu_select, word_offset, write_data, output ready);
endinterface

>>> src/idr_out_if.sv
// response channel of the interrupt distributor register bank
// depends on nothing
interface idr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [31:0] enable_change_mask;
  logic [1:0]  enable_action;
  logic [9:0]  base_intid;
  logic        out_of_range;

  modport source (output valid, read_data, enable_change_mask, enable_action, base_intid,
                  out_of_range, input ready);
  modport sink (input valid, read_data, enable_change_mask, enable_action, base_intid,
                out_of_range, output ready);
endinterface

>>> src/idr_ram.sv
// single-port-write, registered-read record memory
// depends on idr_pkg
module idr_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  idr_pkg::idr_rec_t wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output idr_pkg::idr_rec_t rdata_o
);

  idr_pkg::idr_rec_t mem [DEPTH];
  idr_pkg::idr_rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/idr_rmw.sv
// modify stage: updates one record and packs read data and the enable change mask
// depends on idr_pkg
module idr_rmw (
  input  logic                clk_i,
  input  idr_pkg::idr_stage_t stage_i,
  input  idr_pkg::idr_rec_t   rec_i,
  output idr_pkg::idr_rec_t   rec_o,
  output logic [31:0]         rd_o,
  output logic [31:0]         mask_o
);

  logic [31:0] rd_d, rd_q;
  logic [31:0] mask_d, mask_q;
  logic        bit_sel;
  logic [4:0]  idx;

  always_comb begin
    idx     = stage_i.idx;
    bit_sel = stage_i.wdat[idx];
    rec_o   = rec_i;
    rd_d    = rd_q;
    mask_d  = mask_q;
    if (stage_i.vld) begin
      case (stage_i.cmd)
        idr_pkg::CMD_GRP_RD: begin
          rd_d[idx] = rec_i.grp;
        end
        idr_pkg::CMD_GRP_WR: begin
          rec_o.grp = bit_sel;
        end
        idr_pkg::CMD_EN_RD: begin
          rd_d[idx] = rec_i.en;
        end
        idr_pkg::CMD_SET_EN: begin
          if (bit_sel && !rec_i.en) begin
            rec_o.en    = 1'b1;
            mask_d[idx] = 1'b1;
          end
        end
        idr_pkg::CMD_CLR_EN: begin
          if (bit_sel && rec_i.en) begin
            rec_o.en    = 1'b0;
            mask_d[idx] = 1'b1;
          end
        end
        idr_pkg::CMD_PRIO_RD: begin
          rd_d[{idx[1:0], 3'b000} +: 8] = rec_i.prio;
        end
        idr_pkg::CMD_PRIO_WR: begin
          rec_o.prio = stage_i.wdat[{idx[1:0], 3'b000} +: 8];
        end
        idr_pkg::CMD_CFG_RD: begin
          rd_d[{idx[3:0], 1'b1}] = rec_i.trig_edge;
        end
        idr_pkg::CMD_CFG_WR: begin
          // only the upper bit of each pair counts
          rec_o.trig_edge = stage_i.wdat[{idx[3:0], 1'b1}];
        end
        default: begin
        end
      endcase
    end
    if (stage_i.start) begin
      rd_d   = '0;
      mask_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q   <= rd_d;
    mask_q <= mask_d;
  end

  assign rd_o   = rd_q;
  assign mask_o = mask_q;

endmodule

>>> src/idr_seq.sv
// sequencer: reset clearing pass, word decode, record read issue and write-back
// depends on idr_pkg
module idr_seq #(
  parameter int NUM_VCPU  = idr_pkg::NUM_VCPU_DEF,
  parameter int MAX_INTID = idr_pkg::MAX_INTID_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [9:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic [3:0]          cmd_i,
  input  logic [2:0]          vcpu_i,
  input  logic [7:0]          offset_i,
  input  logic [31:0]         wdat_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  input  idr_pkg::idr_rec_t   rec_mod_i,
  output idr_pkg::idr_stage_t stage_o,
  output idr_pkg::idr_ctrl_t  ctrl_o,
  output idr_pkg::idr_res_t   res_o
);

  localparam int BANK_DEPTH   = NUM_VCPU * 32;
  localparam int SHARED_DEPTH = MAX_INTID - 32;
  localparam int CLR_LEN      = (BANK_DEPTH > SHARED_DEPTH) ? BANK_DEPTH : SHARED_DEPTH;
  localparam int CLR_W        = $clog2(CLR_LEN);
  localparam int AW           = idr_pkg::ADDR_W;

  localparam logic [4:0]       VCPU_LIM = 5'(NUM_VCPU);
  localparam logic [9:0]       SHR_LIM  = 10'(SHARED_DEPTH);
  localparam logic [CLR_W:0]   BANK_LIM = (CLR_W + 1)'(BANK_DEPTH);
  localparam logic [CLR_W:0]   SHR_END  = (CLR_W + 1)'(SHARED_DEPTH);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_LEN - 1);
  localparam logic [5:0]       PER_PRIO = 6'd4;
  localparam logic [5:0]       PER_CFG  = 6'd16;
  localparam logic [5:0]       PER_BIT  = 6'd32;

  idr_pkg::idr_state_e st_d, st_q;
  logic [CLR_W-1:0]    clr_d, clr_q;
  logic [9:0]          nspis_q;
  logic [5:0]          iss_d, iss_q;
  logic                p1_vld_q;
  logic [4:0]          p1_idx_q;
  logic [AW-1:0]       p1_addr_q;

  idr_pkg::idr_cmd_e   cmd_q;
  logic [31:0]         data_q;
  logic [AW-1:0]       base_q;
  logic [AW-1:0]       addr0_q;
  logic                bank_sel_q;
  logic [5:0]          nvalid_q;
  logic                oor_q;

  // decode of the incoming word
  idr_pkg::idr_cmd_e   cmd_in;
  logic                known;
  logic [5:0]          per;
  logic [AW-1:0]       base_in;
  logic                banked;
  logic                vcpu_ok;
  logic [9:0]          nspis_sat;
  logic [AW-1:0]       limit;
  logic [AW-1:0]       avail;
  logic [5:0]          nvalid_in;
  logic                oor_in;
  logic [AW-1:0]       addr0_in;

  logic                accept;
  logic                clearing;
  logic                issue;
  logic                load;
  logic                is_wr;
  logic [AW-1:0]       raddr;

  always_comb begin
    cmd_in = idr_pkg::idr_cmd_e'(cmd_i);
    known  = (cmd_i <= idr_pkg::CMD_CFG_WR);
    case (cmd_in)
      idr_pkg::CMD_PRIO_RD, idr_pkg::CMD_PRIO_WR: begin
        per     = PER_PRIO;
        base_in = {3'b000, offset_i, 2'b00};
      end
      idr_pkg::CMD_CFG_RD, idr_pkg::CMD_CFG_WR: begin
        per     = PER_CFG;
        base_in = {1'b0, offset_i, 4'b0000};
      end
      default: begin
        per     = PER_BIT;
        base_in = {offset_i, 5'b00000};
      end
    endcase
    banked    = (base_in[AW-1:5] == '0);
    vcpu_ok   = ({2'b00, vcpu_i} < VCPU_LIM);
    nspis_sat = (nspis_q > SHR_LIM) ? SHR_LIM : nspis_q;
    limit     = AW'(32) + AW'(nspis_sat);
    avail     = limit - base_in;
    if (banked) begin
      nvalid_in = vcpu_ok ? per : 6'd0;
    end else if (base_in >= limit) begin
      nvalid_in = 6'd0;
    end else if (avail >= AW'(per)) begin
      nvalid_in = per;
    end else begin
      nvalid_in = avail[5:0];
    end
    oor_in   = (nvalid_in != per);
    addr0_in = banked ? ({5'b00000, vcpu_i, 5'b00000} + base_in) : (base_in - AW'(32));
    if (!known) begin
      nvalid_in = 6'd0;
      oor_in    = 1'b0;
      base_in   = '0;
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      idr_pkg::ST_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          st_d = idr_pkg::ST_IDLE;
        end
      end
      idr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          st_d = idr_pkg::ST_RUN;
        end
      end
      idr_pkg::ST_RUN: begin
        if ((iss_q == nvalid_q) && !p1_vld_q) begin
          st_d = idr_pkg::ST_DONE;
        end
      end
      idr_pkg::ST_DONE: begin
        if (out_free_i) begin
          st_d = idr_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = idr_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    clearing   = 1'b0;
    issue      = 1'b0;
    load       = 1'b0;
    case (st_q)
      idr_pkg::ST_CLEAR: clearing   = 1'b1;
      idr_pkg::ST_IDLE:  in_ready_o = 1'b1;
      idr_pkg::ST_RUN:   issue      = (iss_q != nvalid_q);
      idr_pkg::ST_DONE:  load       = out_free_i;
      default: begin
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;
  assign clr_d  = clr_q + CLR_W'(1);
  assign iss_d  = accept ? 6'd0 : (issue ? iss_q + 6'd1 : iss_q);
  assign raddr  = addr0_q + AW'(iss_q);
  assign is_wr  = (cmd_q inside {idr_pkg::CMD_GRP_WR, idr_pkg::CMD_SET_EN, idr_pkg::CMD_CLR_EN,
                                 idr_pkg::CMD_PRIO_WR, idr_pkg::CMD_CFG_WR});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= idr_pkg::ST_CLEAR;
      clr_q    <= '0;
      nspis_q  <= '0;
      iss_q    <= '0;
      p1_vld_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      iss_q    <= iss_d;
      p1_vld_q <= issue;
      if (clearing) begin
        clr_q <= clr_d;
      end
      if (cfg_we_i) begin
        nspis_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_in;
      data_q     <= wdat_i;
      base_q     <= base_in;
      addr0_q    <= addr0_in;
      bank_sel_q <= banked;
      nvalid_q   <= nvalid_in;
      oor_q      <= oor_in;
    end
    if (issue) begin
      p1_idx_q  <= iss_q[4:0];
      p1_addr_q <= raddr;
    end
  end

  // read of record i+1 overlaps the write-back of record i, never the same entry
  always_comb begin
    ctrl_o.re       = issue;
    ctrl_o.raddr    = raddr;
    ctrl_o.bank_sel = bank_sel_q;
    if (clearing) begin
      ctrl_o.bank_we    = ({1'b0, clr_q} < BANK_LIM);
      ctrl_o.shr_we     = ({1'b0, clr_q} < SHR_END);
      ctrl_o.waddr      = AW'(clr_q);
      ctrl_o.bank_wdata = clr_q[4] ? idr_pkg::REC_ZERO : idr_pkg::REC_SGI_RST;
      ctrl_o.shr_wdata  = idr_pkg::REC_ZERO;
    end else begin
      ctrl_o.bank_we    = p1_vld_q && is_wr && bank_sel_q;
      ctrl_o.shr_we     = p1_vld_q && is_wr && !bank_sel_q;
      ctrl_o.waddr      = p1_addr_q;
      ctrl_o.bank_wdata = rec_mod_i;
      ctrl_o.shr_wdata  = rec_mod_i;
    end
  end

  always_comb begin
    stage_o.start = accept;
    stage_o.vld   = p1_vld_q;
    stage_o.idx   = p1_idx_q;
    stage_o.cmd   = cmd_q;
    stage_o.wdat  = data_q;
    res_o.load    = load;
    res_o.oor     = oor_q;
    res_o.base    = base_q[9:0];
    res_o.cmd     = cmd_q;
  end

endmodule

>>> src/interrupt_distributor_registers_core.sv
// Interrupt distributor register bank, top level.
// Channels: in_i carries one register access (cmd, vcpu_select, word_offset,
// write_data); out_o returns one result per access (read_data,
// enable_change_mask, enable_action, base_intid, out_of_range). Both use
// valid/ready; a transaction completes when both are high at a clock edge.
// num_spis is written through cfg_we_i/cfg_wdata_i; the user must do so only while the
// block is idle, as the block does not enforce it. Records live in two memories (banked
// IDs per virtual CPU, shared IDs) and are read, modified and written back one per cycle.
// Flow: after an input transaction the block reads, modifies and writes back the n
// valid records the word touches (up to 32 for group and enable words, 16 for
// config, 4 for priority; none for a word that touches no record), then loads
// the result into the output register once that register is free. It takes the
// next access only in the idle state, entered as the result moves into the output
// register, so it never takes a new access before the last result is in that register.
// Reset: a clearing pass over max(NUM_VCPU*32, MAX_INTID-32) record addresses (992 by
// default) loads the record reset values; in_i.ready stays low meanwhile.
// A stalled receiver holds the result in the output register; one more access
// can be worked on and then waits until the register frees up.
// Depends on idr_pkg, idr_in_if, idr_out_if, idr_ram, idr_rmw, idr_seq, assert_macros.svh.
`include "assert_macros.svh"

module interrupt_distributor_registers_core #(
  parameter int NUM_VCPU  = idr_pkg::NUM_VCPU_DEF,
  parameter int MAX_INTID = idr_pkg::MAX_INTID_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [9:0] cfg_wdata_i,
  idr_in_if.sink    in_i,
  idr_out_if.source out_o
);

  localparam int BANK_DEPTH   = NUM_VCPU * 32;
  localparam int SHARED_DEPTH = MAX_INTID - 32;
  localparam int BANK_AW      = $clog2(BANK_DEPTH);
  localparam int SHR_AW       = $clog2(SHARED_DEPTH);

  idr_pkg::idr_ctrl_t  ctrl;
  idr_pkg::idr_stage_t stage;
  idr_pkg::idr_res_t   res;
  idr_pkg::idr_rec_t   bank_rdata;
  idr_pkg::idr_rec_t   shr_rdata;
  idr_pkg::idr_rec_t   rec_rd;
  idr_pkg::idr_rec_t   rec_mod;
  logic [31:0]         rd_acc;
  logic [31:0]         mask_acc;
  logic                out_free;
  logic                out_vld_q;
  logic [31:0]         read_data_q;
  logic [31:0]         mask_q;
  idr_pkg::idr_act_e   action_d, action_q;
  logic [9:0]          base_q;
  logic                oor_q;
  logic                act_some;
  logic                mask_some;

  idr_ram #(
    .DEPTH (BANK_DEPTH)
  ) u_bank_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.bank_we),
    .waddr_i (ctrl.waddr[BANK_AW-1:0]),
    .wdata_i (ctrl.bank_wdata),
    .re_i    (ctrl.re),
    .raddr_i (ctrl.raddr[BANK_AW-1:0]),
    .rdata_o (bank_rdata)
  );

  idr_ram #(
    .DEPTH (SHARED_DEPTH)
  ) u_shr_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.shr_we),
    .waddr_i (ctrl.waddr[SHR_AW-1:0]),
    .wdata_i (ctrl.shr_wdata),
    .re_i    (ctrl.re),
    .raddr_i (ctrl.raddr[SHR_AW-1:0]),
    .rdata_o (shr_rdata)
  );

  assign rec_rd = ctrl.bank_sel ? bank_rdata : shr_rdata;

  idr_rmw u_rmw (
    .clk_i   (clk_i),
    .stage_i (stage),
    .rec_i   (rec_rd),
    .rec_o   (rec_mod),
    .rd_o    (rd_acc),
    .mask_o  (mask_acc)
  );

  idr_seq #(
    .NUM_VCPU  (NUM_VCPU),
    .MAX_INTID (MAX_INTID)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .cmd_i       (in_i.cmd),
    .vcpu_i      (in_i.vcpu_select),
    .offset_i    (in_i.word_offset),
    .wdat_i      (in_i.write_data),
    .in_ready_o  (in_i.ready),
    .out_free_i  (out_free),
    .rec_mod_i   (rec_mod),
    .stage_o     (stage),
    .ctrl_o      (ctrl),
    .res_o       (res)
  );

  assign out_free = !out_vld_q || out_o.ready;

  always_comb begin
    if (mask_acc == '0) begin
      action_d = idr_pkg::ACT_NONE;
    end else if (res.cmd == idr_pkg::CMD_SET_EN) begin
      action_d = idr_pkg::ACT_ENABLE;
    end else begin
      action_d = idr_pkg::ACT_DISABLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res.load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // reads that reach an invalid ID return zero
  always_ff @(posedge clk_i) begin
    if (res.load) begin
      read_data_q <= res.oor ? '0 : rd_acc;
      mask_q      <= mask_acc;
      action_q    <= action_d;
      base_q      <= res.base;
      oor_q       <= res.oor;
    end
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.read_data          = read_data_q;
  assign out_o.enable_change_mask = mask_q;
  assign out_o.enable_action      = action_q;
  assign out_o.base_intid         = base_q;
  assign out_o.out_of_range       = oor_q;

  assign act_some  = (out_o.enable_action != 2'(idr_pkg::ACT_NONE));
  assign mask_some = (out_o.enable_change_mask != '0);

  `IDR_ASSERT_IMP(a_action_matches_mask, out_o.valid, act_some == mask_some)
  `IDR_ASSERT_IMP(a_oor_reads_zero, out_o.valid && out_o.out_of_range, out_o.read_data == '0)
  `IDR_ASSERT_NXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)
  `IDR_ASSERT_IMP(a_no_write_when_idle, in_i.ready, !(ctrl.bank_we || ctrl.shr_we))

endmodule
